// File: rtl/spml_pkg.sv
// Package: shared types and constants of the stream pattern line matcher.
package spml_pkg;

    // Largest needle the hardware is built for
    localparam int NEEDLE_MAX_DEF = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_NEEDLE_LOW    = 2'd0;
    localparam logic [1:0] REG_NEEDLE_HIGH   = 2'd1;
    localparam logic [1:0] REG_NEEDLE_LENGTH = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;
    localparam int NEEDLE_BYTES = 16;

    // History byte handed from one cell to the next
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_cell_link;

    // Compare setup for one cell
    typedef struct packed {
        logic       active;
        logic [7:0] needle;
    } t_cell_cmp;

endpackage

// File: rtl/spml_in_if.sv
// Interface: input byte channel of the line matcher.
interface spml_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       line_end;

    modport source (output valid, output data_byte, output line_end, input ready);
    modport sink   (input valid, input data_byte, input line_end, output ready);
endinterface

// File: rtl/spml_out_if.sv
// Interface: per-line result channel of the line matcher.
interface spml_out_if;
    logic valid;
    logic ready;
    logic line_match;

    modport source (output valid, output line_match, input ready);
    modport sink   (input valid, input line_match, output ready);
endinterface

// File: rtl/stream_pattern_line_matcher_unit.sv
// Top level: streaming needle matcher over a line-delimited byte stream.
//
//  channel   dir   payload                 transaction
//  i_in      in    data_byte[7:0] line_end valid && ready
//  o_res     out   line_match              valid && ready (only at line ends)
//  i_cfg_*   in    idx[1:0] data[63:0]     i_cfg_we high
//
// One byte per clock while i_in.ready is high: every byte is compared in the
// cycle it is taken, against the incoming byte and a row of NEEDLE_MAX-1
// history cells that shift by one; each line result is registered before o_res.
// i_in.ready drops only while both the output register and the skid register
// hold results that the sink has not taken.
// Reset clears history valid bits, the per-line hit, the needle registers and
// the output and skid valid bits.
module stream_pattern_line_matcher_unit #(
    parameter int NEEDLE_MAX = spml_pkg::NEEDLE_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    spml_in_if.sink                           i_in,
    spml_out_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [spml_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spml_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int HIST_DEPTH = NEEDLE_MAX - 1;
    localparam int LINK_N     = (HIST_DEPTH > 0) ? HIST_DEPTH : 1;
    localparam logic [spml_pkg::LEN_W-1:0] LenMax = spml_pkg::LEN_W'(NEEDLE_MAX);

    // ---------------- configuration registers ----------------
    logic [63:0]                r_needle_low;
    logic [63:0]                r_needle_high;
    logic [spml_pkg::LEN_W-1:0] r_needle_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low  <= '0;
            r_needle_high <= '0;
            r_needle_len  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spml_pkg::REG_NEEDLE_LOW:    r_needle_low  <= i_cfg_data;
                spml_pkg::REG_NEEDLE_HIGH:   r_needle_high <= i_cfg_data;
                spml_pkg::REG_NEEDLE_LENGTH: r_needle_len  <= i_cfg_data[spml_pkg::LEN_W-1:0];
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    // Needle as a byte array, byte 0 first
    logic [7:0] w_needle [spml_pkg::NEEDLE_BYTES];
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_needle[b]     = r_needle_low[8*b +: 8];
            w_needle[b + 8] = r_needle_high[8*b +: 8];
        end
    end

    // Clamp the length to what the cell row covers
    logic [spml_pkg::LEN_W-1:0] w_len;
    assign w_len = (r_needle_len > LenMax) ? LenMax : r_needle_len;

    logic [spml_pkg::LEN_W-1:0] w_last_idx;
    assign w_last_idx = w_len - spml_pkg::LEN_W'(1);

    // ---------------- handshake ----------------
    logic w_accept;
    logic w_take;
    logic w_push;
    logic r_out_valid, r_out_match;
    logic r_skid_valid, r_skid_match;

    assign i_in.ready = !r_skid_valid;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_take     = r_out_valid && o_res.ready;
    assign w_push     = w_accept && i_in.line_end;

    // ---------------- cell row ----------------
    // w_ok[0] is the incoming byte against the needle's last byte,
    // w_ok[k+1] is history cell k.
    logic [HIST_DEPTH:0]  w_ok;
    spml_pkg::t_cell_link w_link [LINK_N];

    assign w_ok[0] = (i_in.data_byte == w_needle[w_last_idx[3:0]]);
    assign w_link[0].valid = 1'b1;
    assign w_link[0].data  = i_in.data_byte;

    for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
        spml_pkg::t_cell_cmp        w_cmp;
        logic [spml_pkg::LEN_W-1:0] w_idx;

        // Cell k holds the byte k+1 places back; it meets needle byte len-2-k
        assign w_idx         = w_len - spml_pkg::LEN_W'(2) - spml_pkg::LEN_W'(k);
        assign w_cmp.active  = (spml_pkg::LEN_W'(k + 1) < w_len);
        assign w_cmp.needle  = w_needle[w_idx[3:0]];

        if (k < HIST_DEPTH - 1) begin : g_mid
            spml_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_link  (w_link[k]),
                .i_cmp   (w_cmp),
                .o_link  (w_link[k + 1]),
                .o_ok    (w_ok[k + 1])
            );
        end else begin : g_tail
            spml_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_link  (w_link[k]),
                .i_cmp   (w_cmp),
                .o_link  (),
                .o_ok    (w_ok[k + 1])
            );
        end
    end

    // An empty needle hits on every byte
    logic w_hit;
    assign w_hit = (w_len == '0) || (&w_ok);

    // ---------------- per-line hit ----------------
    logic r_line_hit;
    logic w_line_match;
    assign w_line_match = r_line_hit || w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_hit <= 1'b0;
        end else if (w_push) begin
            r_line_hit <= 1'b0;
        end else if (w_accept) begin
            r_line_hit <= w_line_match;
        end
    end

    // ---------------- output register and skid ----------------
    logic n_out_valid, n_out_match, n_skid_valid, n_skid_match;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_match  = r_out_match;
        n_skid_valid = r_skid_valid;
        n_skid_match = r_skid_match;
        if (w_take) begin
            if (r_skid_valid) begin
                // advance the skid entry; no push can happen while it is full
                n_out_valid  = 1'b1;
                n_out_match  = r_skid_match;
                n_skid_valid = 1'b0;
            end else if (w_push) begin
                n_out_valid = 1'b1;
                n_out_match = w_line_match;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid) begin
                n_out_valid = 1'b1;
                n_out_match = w_line_match;
            end else begin
                // hold the new result aside while the sink stalls
                n_skid_valid = 1'b1;
                n_skid_match = w_line_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_match  <= n_out_match;
        r_skid_match <= n_skid_match;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.line_match = r_out_match;

endmodule

// File: rtl/spml_cell.sv
// Module: one history cell, holds a stream byte and compares it with its needle byte.
module spml_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  spml_pkg::t_cell_link i_link,
    input  spml_pkg::t_cell_cmp  i_cmp,
    output spml_pkg::t_cell_link o_link,
    output logic                o_ok
);

    logic       r_valid;
    logic [7:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_link.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_link.data;
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.data  = r_data;

    // Pass when unused, else the byte must be seen and equal
    assign o_ok = !i_cmp.active || (r_valid && (r_data == i_cmp.needle));

endmodule

// File: tb/stream_pattern_line_matcher_unit_test.sv
// Testbench: self-checking stream and result check of the stream pattern line matcher.
module stream_pattern_line_matcher_unit_test;

    // Spare index: the block must ignore writes to it
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int HIST_DEPTH = spml_pkg::NEEDLE_MAX_DEF - 1;
    // Quiet cycles tolerated before the run is declared hung
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_end;
    } t_stream_byte;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [spml_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [spml_pkg::CFG_DATA_W-1:0] i_cfg_data;

    spml_in_if  byte_bus ();
    spml_out_if match_bus ();

    stream_pattern_line_matcher_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (byte_bus),
        .o_res      (match_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bytes waiting to be sent; the head is on the bus while valid is high
    t_stream_byte byte_backlog[$];
    // One expected line_match per closed line, oldest first
    bit           line_match_expected[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  byte_taken     = 1'b0;
    int  mismatches     = 0;
    int  quiet_cycles   = 0;

    // Matcher shadow: needle registers, recent bytes (newest at 0), count, line hit
    logic [63:0]                needle_lo_q  = '0;
    logic [63:0]                needle_hi_q  = '0;
    logic [spml_pkg::LEN_W-1:0] needle_len_q = '0;
    logic [7:0]                 recent_bytes [HIST_DEPTH];
    int                         recent_count = 0;
    bit                         hit_in_line  = 1'b0;

    function automatic int needle_span();
        return (needle_len_q > spml_pkg::NEEDLE_MAX_DEF) ? spml_pkg::NEEDLE_MAX_DEF
                                                         : int'(needle_len_q);
    endfunction

    function automatic logic [7:0] needle_byte(int k);
        return (k < 8) ? needle_lo_q[k*8 +: 8] : needle_hi_q[(k-8)*8 +: 8];
    endfunction

    function automatic bit needle_ends_at(logic [7:0] b);
        int span;
        int k;
        span = needle_span();
        if (span == 0) return 1'b1;
        if (recent_count < span - 1) return 1'b0;
        if (b != needle_byte(span - 1)) return 1'b0;
        for (k = 0; k < span - 1; k++) begin
            if (recent_bytes[k] != needle_byte(span - 2 - k)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the shadow by one accepted byte; queue a result at a line end
    function automatic void absorb_byte(logic [7:0] b, logic last);
        int k;
        if (needle_ends_at(b)) hit_in_line = 1'b1;
        for (k = HIST_DEPTH - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
        recent_bytes[0] = b;
        if (recent_count < HIST_DEPTH) recent_count++;
        if (last) begin
            line_match_expected.push_back(hit_in_line);
            hit_in_line = 1'b0;
        end
    endfunction

    function automatic void queue_item(logic [7:0] b, logic last);
        t_stream_byte item;
        item.data_byte = b;
        item.line_end  = last;
        byte_backlog.push_back(item);
    endfunction

    // Close a line on roughly one byte in seven
    function automatic void queue_byte(logic [7:0] b);
        queue_item(b, $urandom_range(0, 6) == 0);
    endfunction

    // Write one register at a falling edge; the shadow follows at once
    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            spml_pkg::REG_NEEDLE_LOW:    needle_lo_q  = value;
            spml_pkg::REG_NEEDLE_HIGH:   needle_hi_q  = value;
            spml_pkg::REG_NEEDLE_LENGTH: needle_len_q = value[spml_pkg::LEN_W-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold until every byte is sent and every line result is back, then let
    // the pipeline settle before anything is reconfigured
    task automatic drain_results();
        while (byte_backlog.size() != 0 || line_match_expected.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Random stream built mostly from the needle: full copies, copies with one
    // bit flipped, prefixes, runs of needle or alphabet bytes, and random bytes
    task automatic fill_stream(int n_items, bit narrow);
        int span;
        int roll;
        int flip_at;
        int cut;
        int n;
        int k;
        logic [7:0] b;
        span = needle_span();
        while (byte_backlog.size() < n_items) begin
            roll = $urandom_range(0, 9);
            if (span > 0 && roll <= 3) begin
                flip_at = (roll == 3) ? $urandom_range(0, span - 1) : -1;
                for (k = 0; k < span; k++) begin
                    b = needle_byte(k);
                    if (k == flip_at) b = b ^ (8'h01 << $urandom_range(0, 7));
                    queue_byte(b);
                end
            end else if (span > 1 && roll <= 5) begin
                cut = $urandom_range(1, span - 1);
                for (k = 0; k < cut; k++) queue_byte(needle_byte(k));
            end else if (roll <= 8) begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) begin
                    if (narrow)
                        b = 8'(8'h61 + $urandom_range(0, 1));
                    else if (span > 0)
                        b = needle_byte($urandom_range(0, span - 1));
                    else
                        b = 8'($urandom_range(0, 255));
                    queue_byte(b);
                end
            end else begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) queue_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // One phase: pick the handshake pressure, load a needle, stream, drain
    task automatic run_phase(int n_items, logic [spml_pkg::LEN_W-1:0] len, bit narrow,
                             int mode);
        logic [63:0] lo;
        logic [63:0] hi;
        int k;
        for (k = 0; k < 8; k++) begin
            lo[k*8 +: 8] = narrow ? 8'(8'h61 + $urandom_range(0, 1))
                                  : 8'($urandom_range(0, 255));
            hi[k*8 +: 8] = narrow ? 8'(8'h61 + $urandom_range(0, 1))
                                  : 8'($urandom_range(0, 255));
        end
        case (mode)
            1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
            3:       begin send_idle_pct = 35; recv_stall_pct = 35; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
        write_reg(spml_pkg::REG_NEEDLE_LOW, lo);
        write_reg(spml_pkg::REG_NEEDLE_HIGH, hi);
        write_reg(spml_pkg::REG_NEEDLE_LENGTH,
                  {{(spml_pkg::CFG_DATA_W-spml_pkg::LEN_W){1'b0}}, len});
        fill_stream(n_items, narrow);
        drain_results();
    endtask

    // Driver: change inputs at the falling edge; keep a byte on the bus until taken
    always @(negedge i_clk) begin : drive_stream
        logic hold;
        hold = byte_bus.valid && !byte_taken;
        if (!hold) begin
            if (i_rst_n && byte_backlog.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                byte_bus.valid     <= 1'b1;
                byte_bus.data_byte <= byte_backlog[0].data_byte;
                byte_bus.line_end  <= byte_backlog[0].line_end;
            end else begin
                byte_bus.valid <= 1'b0;
            end
        end
        match_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: predict on each byte transaction, check each result transaction
    always @(posedge i_clk) begin : watch_ports
        bit want;
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (byte_bus.valid && byte_bus.ready) begin
                absorb_byte(byte_bus.data_byte, byte_bus.line_end);
                void'(byte_backlog.pop_front());
                byte_taken = 1'b1;
            end
            if (match_bus.valid && match_bus.ready) begin
                if (line_match_expected.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual line_match %b",
                             $time, match_bus.line_match);
                    mismatches++;
                end else begin
                    want = line_match_expected.pop_front();
                    if (match_bus.line_match !== want) begin
                        $display("%0t: line_match mismatch, expected %b, actual %b",
                                 $time, want, match_bus.line_match);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: stop a run in which no transaction moves for too long
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (byte_bus.valid && byte_bus.ready) ||
            (match_bus.valid && match_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("stream_pattern_line_matcher_unit_test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int p;
        int k;
        logic [spml_pkg::LEN_W-1:0] len;
        for (k = 0; k < HIST_DEPTH; k++) recent_bytes[k] = 8'h00;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        byte_bus.valid     = 1'b0;
        byte_bus.data_byte = 8'h00;
        byte_bus.line_end  = 1'b0;
        match_bus.ready    = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Short history: the history cells emptied at reset must not form a match
        write_reg(spml_pkg::REG_NEEDLE_LOW, 64'h0);
        write_reg(spml_pkg::REG_NEEDLE_HIGH, 64'h0);
        write_reg(spml_pkg::REG_NEEDLE_LENGTH, 64'd2);
        queue_item(8'h00, 1'b1);
        queue_item(8'h00, 1'b0);
        queue_item(8'h00, 1'b1);
        drain_results();

        // Empty needle: every line matches
        write_reg(spml_pkg::REG_NEEDLE_LENGTH, 64'd0);
        queue_item(8'hFF, 1'b0);
        queue_item(8'h5A, 1'b1);
        queue_item(8'h00, 1'b1);
        drain_results();

        // Overlong length clamps to the full needle; the match spans two lines
        // and the stream stops mid-line so the hit carries into the next setting
        write_reg(spml_pkg::REG_NEEDLE_LOW, '1);
        write_reg(spml_pkg::REG_NEEDLE_HIGH, '1);
        write_reg(spml_pkg::REG_NEEDLE_LENGTH, 64'd31);
        for (k = 0; k < spml_pkg::NEEDLE_MAX_DEF; k++) queue_item(8'hFF, k == 3);
        drain_results();
        write_reg(REG_SPARE, {$urandom, $urandom});

        // Random phases across needle lengths and handshake pressure
        for (p = 0; p < 12; p++) begin
            case (p)
                0:       len = 5'd1;
                1:       len = 5'd16;
                2:       len = 5'd0;
                3:       len = 5'd31;
                4:       len = 5'd2;
                5:       len = 5'd15;
                6:       len = 5'd17;
                default: len = 5'($urandom_range(1, 16));
            endcase
            run_phase(120, len, p % 2 == 1, p % 4);
        end

        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && line_match_expected.size() == 0)
            $display("stream_pattern_line_matcher_unit_test passed");
        else
            $display("stream_pattern_line_matcher_unit_test failed");
        $finish;
    end

endmodule

// File: stream_pattern_line_matcher_unit.f
rtl/spml_pkg.sv
rtl/spml_in_if.sv
rtl/spml_out_if.sv
rtl/spml_cell.sv
rtl/stream_pattern_line_matcher_unit.sv
tb/stream_pattern_line_matcher_unit_test.sv
